@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Word types, operation and status codes, controller state and the command
// and status groups that link the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // data word returned by a dequeue on an empty queue
   localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] data_in;
      logic [7:0]         priority_req;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      status_type         status;
      logic [4:0]         fill_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DEQ_DATA,
      ST_SCAN,
      ST_PLACE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;    // take the request word
      logic read_head;  // read the head entry
      logic scan_start; // aim at the tail, read the entry above it
      logic scan_step;  // move the entry above down one slot
      logic place_new;  // write the new entry at the current slot
      logic deq_done;   // pop the head
      logic set_empty;  // result: dequeue on empty queue
      logic set_full;   // result: enqueue dropped
      logic load_out;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic op_deq;
      logic empty;
      logic full;
      logic outrank;    // entry read back ranks at or above the new one
      logic last;       // entry read back is the head
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/core/spq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences dequeue, insertion walk and response hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::dp_status_type sts,
   output spq_pkg::cmd_type      cmd
);

   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (sts.op_deq && sts.empty) begin
               state_in = ST_RESPOND;
            end else if (sts.op_deq) begin
               state_in = ST_DEQ_DATA;
            end else if (sts.full) begin
               state_in = ST_RESPOND;
            end else if (sts.empty) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DEQ_DATA: state_in = ST_RESPOND;
         ST_SCAN: begin
            priority if (sts.outrank) begin
               state_in = ST_RESPOND;
            end else if (sts.last) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_PLACE: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            priority if (sts.op_deq && sts.empty) begin
               cmd.set_empty = 1'b1;
            end else if (sts.op_deq) begin
               cmd.read_head = 1'b1;
            end else if (sts.full) begin
               cmd.set_full = 1'b1;
            end else begin
               cmd.scan_start = 1'b1;
            end
         end
         ST_DEQ_DATA: cmd.deq_done = 1'b1;
         ST_SCAN: begin
            if (sts.outrank) begin
               cmd.place_new = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_PLACE: cmd.place_new = 1'b1;
         ST_RESPOND: cmd.load_out = sts.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Circular entry store in RAM, head and count, insertion walk from the tail,
// result and output registers.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::req_type       req,
   output spq_pkg::rsp_type       rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spq_pkg::cmd_type       cmd,
   output spq_pkg::dp_status_type sts
);

   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = 32 + PRIORITY_BITS;

   req_type                  req_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [AW-1:0]            slot_ff, slot_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic signed [31:0]       res_data_ff, res_data_in;
   status_type               res_status_ff, res_status_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [AW:0]              tail_sum;
   logic [AW-1:0]            tail;
   logic [PRIORITY_BITS-1:0] prio_new;
   logic [EW-1:0]            rd_word;
   logic [PRIORITY_BITS-1:0] rd_prio;
   logic [31:0]              rd_data_w;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [EW-1:0]            wr_word;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   // tail slot, one past the last entry
   assign tail_sum = {1'b0, head_ff} + (AW + 1)'(count_ff);
   assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);

   assign prio_new  = PRIORITY_BITS'(req_ff.priority_req);
   assign rd_prio   = rd_word[PRIORITY_BITS-1:0];
   assign rd_data_w = rd_word[EW-1:PRIORITY_BITS];

   // RAM port selection
   assign rd_en   = cmd.read_head | cmd.scan_start | cmd.scan_step;
   assign wr_en   = cmd.scan_step | cmd.place_new;
   assign wr_addr = slot_ff;
   assign wr_word = cmd.scan_step ? rd_word : {req_ff.data_in, prio_new};

   always_comb begin
      rd_addr = head_ff;
      if (cmd.scan_start) begin
         rd_addr = ptr_dec(tail);
      end else if (cmd.scan_step) begin
         rd_addr = ptr_dec(ptr_dec(slot_ff));
      end
   end

   spq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // queue bookkeeping and walk pointer
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      slot_in  = slot_ff;
      rem_in   = rem_ff;
      if (cmd.place_new) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.deq_done) begin
         count_in = count_ff - CW'(1);
         head_in  = ptr_inc(head_ff);
      end
      if (cmd.scan_start) begin
         slot_in = tail;
         rem_in  = count_ff;
      end
      if (cmd.scan_step) begin
         slot_in = ptr_dec(slot_ff);
         rem_in  = rem_ff - CW'(1);
      end
   end

   // result word
   always_comb begin
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      priority if (cmd.set_empty) begin
         res_data_in   = EMPTY_WORD;
         res_status_in = STATUS_EMPTY;
      end else if (cmd.set_full) begin
         res_data_in   = '0;
         res_status_in = STATUS_FULL;
      end else if (cmd.place_new) begin
         res_data_in   = '0;
         res_status_in = STATUS_OK;
      end else if (cmd.deq_done) begin
         res_data_in   = rd_data_w;
         res_status_in = STATUS_OK;
      end
   end

   // output register: load a new word or drop the taken one
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_in.data_out   = res_data_ff;
         rsp_in.status     = res_status_ff;
         rsp_in.fill_count = 5'(count_ff);
         rsp_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      slot_ff       <= slot_in;
      rem_ff        <= rem_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   // status toward the controller
   assign sts.op_deq   = (req_ff.op == OP_DEQUEUE);
   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CW'(DEPTH));
   assign sts.outrank  = (rd_prio >= prio_new);
   assign sts.last     = (rem_ff == CW'(1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue
// Holds up to DEPTH entries in descending priority order, equal priorities
// served first in, first out.
// ----------------------------------------------------------------------------
// Usage: send one word per operation on req_word (op, data_in, priority_req);
// every accepted word returns exactly one rsp_word (data_out, status,
// fill_count) in order. An enqueue goes after the last entry whose priority
// is at least its own; a dequeue returns the head.
// After accept, a dequeue on an empty queue or an enqueue on a full one goes
// from decode straight to the response; a dequeue reads the head and pops it,
// an enqueue into an empty queue is written directly, and any other enqueue
// walks from the tail, moving each lower-priority entry down one slot.
// req_ready is high again in the cycle rsp_valid rises. The insertion walk
// reads and rewrites one entry per cycle through the single-port-pair RAM.
// Reset empties the queue at once (count and head cleared, no RAM sweep).
// The response waits in an output register while rsp_ready is low; the next
// request is still accepted, and its result holds in the result register
// until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_word
);

   import spq_pkg::*;

   cmd_type       cmd;
   dp_status_type sts;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_word),
      .rsp       (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // one operation in flight: accepting closes the input until it completes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an operation is in flight");

   // empty-queue dequeue reports the marker word and an empty count
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == STATUS_EMPTY) |->
         (rsp_word.data_out == EMPTY_WORD && rsp_word.fill_count == 5'd0))
      else $error("empty status without marker word or zero count");

   // dropped enqueue reports a full queue
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == STATUS_FULL) |->
         (rsp_word.data_out == '0 && rsp_word.fill_count == 5'(DEPTH)))
      else $error("full status with wrong word or count");

   // never pop and push, or shift and push, in the same cycle
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.deq_done && cmd.place_new) && !(cmd.scan_step && cmd.place_new))
      else $error("conflicting datapath commands");

endmodule
